// File: design/ray_box_face_intersections_defines.svh
// Assertion helpers for the ray/box top-level design file.
// Every check is clocked on clk and held off while arst_n is low.
`ifndef RAY_BOX_FACE_INTERSECTIONS_DEFINES_SVH
`define RAY_BOX_FACE_INTERSECTIONS_DEFINES_SVH

// Same-cycle implication.
`define RBFI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbfi assertion failed");

// Next-cycle implication.
`define RBFI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbfi assertion failed");

`endif

// File: design/rbfi_pkg.sv
`default_nettype none
package rbfi_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int SIZE_W    = 31;
	localparam int PREC_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = SIZE_W;
	localparam int NUM_FACES = 6;
	localparam int FACE_W    = 3;

	// Numerator of the face plane equation: +-size - 2*pos.
	localparam int NUM_W = ((SIZE_W > COORD_W + 1) ? SIZE_W : COORD_W + 1) + 2;
	localparam int MAG_W = NUM_W - 1;
	localparam int DVD_W = MAG_W + FRAC_W;
	localparam int DVS_W = COORD_W + 1;
	localparam int QUO_W = COORD_W + 1;
	localparam int REM_W = COORD_W + 2;
	localparam int HI_W  = DVD_W - QUO_W;
	localparam int HX_W  = (HI_W > REM_W) ? HI_W : REM_W;
	localparam int DIV_LAT = QUO_W + 1;

	// Hit point arithmetic.
	localparam int PROD_W = 2 * COORD_W;
	localparam int RND_W  = PROD_W + 1;
	localparam int SHF_W  = RND_W - FRAC_W;
	localparam int CRD_W  = ((SHF_W > COORD_W) ? SHF_W : COORD_W) + 1;
	localparam int CMP_W  = ((CRD_W + 1 > SIZE_W + 1) ? CRD_W + 1 : SIZE_W + 1) + 1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [QUO_W-1:0] QMAG_POS = {2'b00, {(COORD_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] QMAG_NEG = {2'b01, {(COORD_W-1){1'b0}}};
	localparam logic signed [RND_W-1:0] HALF_LSB =
		$signed({{(RND_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_X,
		CFG_SIZE_Y,
		CFG_SIZE_Z,
		CFG_PRECISION
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
	} ray_in_t;

	typedef struct packed {
		logic                      hit_valid;
		logic signed [COORD_W-1:0] distance;
		logic signed [COORD_W-1:0] hit_x;
		logic signed [COORD_W-1:0] hit_y;
		logic signed [COORD_W-1:0] hit_z;
		logic [FACE_W-1:0]         face;
		logic                      entering;
		logic                      last;
	} hit_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] t;
		logic signed [COORD_W-1:0] pt_x;
		logic signed [COORD_W-1:0] pt_y;
		logic signed [COORD_W-1:0] pt_z;
		logic [FACE_W-1:0]         face;
		logic                      enter;
	} hit_rec_t;

endpackage
`default_nettype wire

// File: design/rbfi_div.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
// The quotient is computed to QUO_W bits; a larger quotient raises ovf.
module rbfi_div
	import rbfi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic      [QUO_W-1:0] quotient,
	output logic                  ovf
);

	logic [REM_W-1:0] rem_q [QUO_W+1];
	logic [QUO_W-1:0] low_q [QUO_W+1];
	logic [QUO_W-1:0] quo_q [QUO_W+1];
	logic [DVS_W-1:0] dvs_q [QUO_W+1];
	logic             ovf_q [QUO_W+1];

	logic [HX_W-1:0] hi_ext;

	assign hi_ext = HX_W'(dividend >> QUO_W);

	// The high part must stay below the divisor, or the quotient does not fit.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= hi_ext[REM_W-1:0];
			low_q[0] <= dividend[QUO_W-1:0];
			quo_q[0] <= '0;
			dvs_q[0] <= divisor;
			ovf_q[0] <= (hi_ext >= HX_W'(divisor));
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
		logic [REM_W-1:0] trial;
		logic             ge;

		assign trial = {rem_q[k-1][REM_W-2:0], low_q[k-1][QUO_W-1]};
		assign ge    = (trial >= REM_W'(dvs_q[k-1]));

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? (trial - REM_W'(dvs_q[k-1])) : trial;
				low_q[k] <= {low_q[k-1][QUO_W-2:0], 1'b0};
				quo_q[k] <= {quo_q[k-1][QUO_W-2:0], ge};
				dvs_q[k] <= dvs_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	assign quotient = quo_q[QUO_W];
	assign ovf      = ovf_q[QUO_W];

endmodule
`default_nettype wire

// File: design/ray_box_face_intersections.sv
`default_nettype none
// Ray against a centered axis-aligned box: sorted face hits.
// Input channel in_valid/in_ready/in_data carries one ray (origin and direction,
// signed Q16.16). Output channel out_valid/out_ready/out_data carries the hits
// of each ray in ascending distance, ties in face order, last set on the final
// one; a ray with no hit yields one transaction with hit_valid low and last set.
// Box sizes and the snap threshold are written on cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no ray is in flight; the block does not check.
// One ray can enter every cycle while the pipeline is not held. The pipeline is
// made of the numerator stage, the bit-per-stage face dividers (34 stages), then
// sign/saturate, multiply, hit point and bounds, ordering, and the result
// register.
// Output: the result register sends one transaction a cycle while out_ready is
// high, so a ray with n hits gives max(n, 1) output transactions.
// When the receiver stalls, or a ray's hits are still being sent, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits, sets the sizes to 0 and the threshold to 1 LSB.
module ray_box_face_intersections
	import rbfi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ray_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output hit_out_t                  out_data
);

	`include "ray_box_face_intersections_defines.svh"

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [PREC_W-1:0] prec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= '0;
			size_y_q <= '0;
			size_z_q <= '0;
			prec_q   <= PREC_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SIZE_X:    size_x_q <= cfg_wdata[SIZE_W-1:0];
				CFG_SIZE_Y:    size_y_q <= cfg_wdata[SIZE_W-1:0];
				CFG_SIZE_Z:    size_z_q <= cfg_wdata[SIZE_W-1:0];
				CFG_PRECISION: prec_q   <= cfg_wdata[PREC_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SIZE_W-1:0] sz [3];
	assign sz[0] = size_x_q;
	assign sz[1] = size_y_q;
	assign sz[2] = size_z_q;

	function automatic logic [2:0] popcount6(input logic [NUM_FACES-1:0] v);
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < NUM_FACES; i++) begin
			n = n + 3'(v[i]);
		end
		return n;
	endfunction

	// Global advance: the pipeline moves whenever the result register frees up.
	logic adv;
	logic out_last;
	logic rec_vld_q;
	logic [2:0] idx_q;
	logic [2:0] rec_cnt_q;
	hit_rec_t rec_slot_q [NUM_FACES];

	assign out_last = (rec_cnt_q == 3'd0) || (idx_q == rec_cnt_q - 3'd1);
	assign adv      = !rec_vld_q || (out_ready && out_last);
	assign in_ready = adv;

	// Stage 1: numerators and divisors of the six face planes.
	logic signed [COORD_W-1:0] pin [3];
	logic signed [COORD_W-1:0] din [3];
	assign pin[0] = in_data.pos_x;
	assign pin[1] = in_data.pos_y;
	assign pin[2] = in_data.pos_z;
	assign din[0] = in_data.dir_x;
	assign din[1] = in_data.dir_y;
	assign din[2] = in_data.dir_z;

	logic [DVD_W-1:0]     dvd_c [NUM_FACES];
	logic [DVS_W-1:0]     dvs_c [NUM_FACES];
	logic [NUM_FACES-1:0] qneg_c;

	always_comb begin
		logic signed [NUM_W-1:0] s_ext;
		logic signed [NUM_W-1:0] p_ext;
		logic signed [NUM_W-1:0] num;
		logic signed [NUM_W-1:0] mag;
		logic signed [DVS_W-1:0] dx;
		logic signed [DVS_W-1:0] dabs;
		for (int f = 0; f < NUM_FACES; f++) begin
			s_ext = $signed(NUM_W'(sz[f/2]));
			p_ext = NUM_W'(pin[f/2]);
			num   = ((f % 2 == 1) ? -s_ext : s_ext) - (p_ext <<< 1);
			mag   = num[NUM_W-1] ? -num : num;
			dx    = DVS_W'(din[f/2]);
			dabs  = dx[DVS_W-1] ? -dx : dx;
			dvd_c[f]  = {mag[MAG_W-1:0], {FRAC_W{1'b0}}};
			dvs_c[f]  = {dabs[COORD_W-1:0], 1'b0};
			qneg_c[f] = num[NUM_W-1] ^ din[f/2][COORD_W-1];
		end
	end

	logic                 vld_s1;
	ray_in_t              ray_s1;
	logic [DVD_W-1:0]     dvd_s1 [NUM_FACES];
	logic [DVS_W-1:0]     dvs_s1 [NUM_FACES];
	logic [NUM_FACES-1:0] qneg_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1  <= in_data;
			dvd_s1  <= dvd_c;
			dvs_s1  <= dvs_c;
			qneg_s1 <= qneg_c;
		end
	end

	// Dividers with the ray data travelling alongside.
	logic [QUO_W-1:0]     quo [NUM_FACES];
	logic [NUM_FACES-1:0] qovf;

	for (genvar f = 0; f < NUM_FACES; f++) begin : g_div
		rbfi_div u_div (
			.clk      (clk),
			.en       (adv),
			.dividend (dvd_s1[f]),
			.divisor  (dvs_s1[f]),
			.quotient (quo[f]),
			.ovf      (qovf[f])
		);
	end

	logic                 vld_p  [DIV_LAT];
	ray_in_t              ray_p  [DIV_LAT];
	logic [NUM_FACES-1:0] qneg_p [DIV_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_p[0]  <= ray_s1;
			qneg_p[0] <= qneg_s1;
			for (int k = 1; k < DIV_LAT; k++) begin
				ray_p[k]  <= ray_p[k-1];
				qneg_p[k] <= qneg_p[k-1];
			end
		end
	end

	// Stage 2: sign, saturation and snapping of t.
	logic signed [COORD_W-1:0] t_c [NUM_FACES];

	always_comb begin
		logic [QUO_W-1:0] neg_mag;
		for (int f = 0; f < NUM_FACES; f++) begin
			neg_mag = -quo[f];
			if (qneg_p[DIV_LAT-1][f]) begin
				t_c[f] = (qovf[f] || quo[f] > QMAG_NEG) ? COORD_MIN
					: $signed(neg_mag[COORD_W-1:0]);
			end else begin
				t_c[f] = (qovf[f] || quo[f] > QMAG_POS) ? COORD_MAX
					: $signed(quo[f][COORD_W-1:0]);
			end
			if (t_c[f] > 0 && t_c[f] < $signed(COORD_W'(prec_q))) begin
				t_c[f] = '0;
			end
		end
	end

	logic                      vld_s2;
	ray_in_t                   ray_s2;
	logic signed [COORD_W-1:0] t_s2 [NUM_FACES];

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s2 <= ray_p[DIV_LAT-1];
			t_s2   <= t_c;
		end
	end

	// Stage 3: t times each direction component.
	logic signed [COORD_W-1:0] d_s2 [3];
	assign d_s2[0] = ray_s2.dir_x;
	assign d_s2[1] = ray_s2.dir_y;
	assign d_s2[2] = ray_s2.dir_z;

	logic                      vld_s3;
	ray_in_t                   ray_s3;
	logic signed [COORD_W-1:0] t_s3 [NUM_FACES];
	logic signed [PROD_W-1:0]  prod_s3 [NUM_FACES][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s3 <= ray_s2;
			t_s3   <= t_s2;
			for (int f = 0; f < NUM_FACES; f++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s3[f][i] <= PROD_W'(t_s2[f]) * PROD_W'(d_s2[i]);
				end
			end
		end
	end

	// Stage 4: hit point, bounds test and coordinate saturation.
	logic signed [COORD_W-1:0] p_s3 [3];
	logic signed [COORD_W-1:0] d_s3 [3];
	assign p_s3[0] = ray_s3.pos_x;
	assign p_s3[1] = ray_s3.pos_y;
	assign p_s3[2] = ray_s3.pos_z;
	assign d_s3[0] = ray_s3.dir_x;
	assign d_s3[1] = ray_s3.dir_y;
	assign d_s3[2] = ray_s3.dir_z;

	hit_rec_t             hit_c [NUM_FACES];
	logic [NUM_FACES-1:0] hv_c;

	always_comb begin
		logic signed [RND_W-1:0]   rnd;
		logic signed [SHF_W-1:0]   sh;
		logic signed [CRD_W-1:0]   c;
		logic signed [CMP_W-1:0]   c2;
		logic signed [CMP_W-1:0]   bnd;
		logic signed [COORD_W-1:0] cs [3];
		logic                      in_box;
		for (int f = 0; f < NUM_FACES; f++) begin
			in_box = 1'b1;
			for (int i = 0; i < 3; i++) begin
				rnd = RND_W'(prod_s3[f][i]) + HALF_LSB;
				sh  = $signed(rnd[RND_W-1:FRAC_W]);
				c   = CRD_W'(sh) + CRD_W'(p_s3[i]);
				c2  = CMP_W'(c) <<< 1;
				bnd = $signed(CMP_W'(sz[i]));
				if (i != f / 2 && (c2 < -bnd || c2 > bnd)) begin
					in_box = 1'b0;
				end
				if (c > CRD_W'(COORD_MAX)) begin
					cs[i] = COORD_MAX;
				end else if (c < CRD_W'(COORD_MIN)) begin
					cs[i] = COORD_MIN;
				end else begin
					cs[i] = c[COORD_W-1:0];
				end
			end
			hit_c[f].t     = t_s3[f];
			hit_c[f].pt_x  = cs[0];
			hit_c[f].pt_y  = cs[1];
			hit_c[f].pt_z  = cs[2];
			hit_c[f].face  = FACE_W'(f);
			// A ray enters through the low face when moving up the axis.
			hit_c[f].enter = (f % 2 == 1) ? (d_s3[f/2] > 0) : (d_s3[f/2] < 0);
			hv_c[f]        = in_box && (d_s3[f/2] != 0);
		end
	end

	logic                 vld_s4;
	hit_rec_t             hit_s4 [NUM_FACES];
	logic [NUM_FACES-1:0] hv_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s4 <= hit_c;
			hv_s4  <= hv_c;
		end
	end

	// Stage 5: which valid hits sort ahead of each face (stable on ties).
	logic [NUM_FACES-1:0] ahead_c [NUM_FACES];

	always_comb begin
		for (int i = 0; i < NUM_FACES; i++) begin
			for (int j = 0; j < NUM_FACES; j++) begin
				ahead_c[i][j] = hv_s4[j] && (hit_s4[j].t < hit_s4[i].t
					|| (hit_s4[j].t == hit_s4[i].t && j < i));
			end
		end
	end

	logic                 vld_s5;
	hit_rec_t             hit_s5 [NUM_FACES];
	logic [NUM_FACES-1:0] hv_s5;
	logic [NUM_FACES-1:0] ahead_s5 [NUM_FACES];

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s5   <= hit_s4;
			hv_s5    <= hv_s4;
			ahead_s5 <= ahead_c;
		end
	end

	// Result register: hits placed by rank, then sent one per cycle while out_ready is high.
	hit_rec_t slot_c [NUM_FACES];

	always_comb begin
		for (int k = 0; k < NUM_FACES; k++) begin
			slot_c[k] = '0;
			for (int i = 0; i < NUM_FACES; i++) begin
				if (hv_s5[i] && popcount6(ahead_s5[i]) == 3'(k)) begin
					slot_c[k] = hit_s5[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_slot_q <= slot_c;
			rec_cnt_q  <= popcount6(hv_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			rec_vld_q <= 1'b0;
			idx_q     <= '0;
			for (int k = 0; k < DIV_LAT; k++) begin
				vld_p[k] <= 1'b0;
			end
		end else begin
			if (adv) begin
				vld_s1   <= in_valid;
				vld_p[0] <= vld_s1;
				for (int k = 1; k < DIV_LAT; k++) begin
					vld_p[k] <= vld_p[k-1];
				end
				vld_s2    <= vld_p[DIV_LAT-1];
				vld_s3    <= vld_s2;
				vld_s4    <= vld_s3;
				vld_s5    <= vld_s4;
				rec_vld_q <= vld_s5;
				idx_q     <= '0;
			end else if (out_ready) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	hit_rec_t sel;
	assign sel       = rec_slot_q[idx_q];
	assign out_valid = rec_vld_q;

	always_comb begin
		out_data = '0;
		out_data.last = out_last;
		if (rec_cnt_q != 3'd0) begin
			out_data.hit_valid = 1'b1;
			out_data.distance  = sel.t;
			out_data.hit_x     = sel.pt_x;
			out_data.hit_y     = sel.pt_y;
			out_data.hit_z     = sel.pt_z;
			out_data.face      = sel.face;
			out_data.entering  = sel.enter;
		end
	end

	`RBFI_ASSERT_IMP(a_nohit_is_last, out_valid && !out_data.hit_valid, out_data.last)
	`RBFI_ASSERT_NXT(a_more_follow, out_valid && out_ready && !out_data.last,
		out_valid && out_data.hit_valid)
	`RBFI_ASSERT_NXT(a_sorted, out_valid && out_ready && !out_data.last,
		out_data.distance >= $past(out_data.distance))
	`RBFI_ASSERT_NXT(a_tie_order, out_valid && out_ready && !out_data.last,
		out_data.distance != $past(out_data.distance) || out_data.face > $past(out_data.face))

endmodule
`default_nettype wire

// File: dv/ray_box_face_intersections_test.sv
`default_nettype none
module ray_box_face_intersections_test;
	import rbfi_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	ray_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	hit_out_t out_data;

	ray_box_face_intersections u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	// Local copy of the box registers.
	longint box_size [3];
	longint snap_thresh;

	hit_out_t pending_hits [$];
	int error_count = 0;
	bit calm = 1'b0;

	function automatic longint clamp_coord(longint v);
		if (v > longint'(COORD_MAX))
			return longint'(COORD_MAX);
		if (v < longint'(COORD_MIN))
			return longint'(COORD_MIN);
		return v;
	endfunction

	// Floor division by 2^FRAC_W; arithmetic shift floors in SystemVerilog.
	function automatic longint floor_frac(longint p);
		return p >>> FRAC_W;
	endfunction

	task automatic predict_hits(input ray_in_t r);
		longint p [3];
		longint d [3];
		longint c [3];
		longint num, t;
		hit_out_t found [$];
		hit_out_t h;
		int ax, k;
		bit neg, in_box;
		p[0] = longint'(r.pos_x); p[1] = longint'(r.pos_y); p[2] = longint'(r.pos_z);
		d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
		for (int f = 0; f < NUM_FACES; f++) begin
			ax = f >> 1;
			neg = f[0];
			if (d[ax] == 0)
				continue;
			num = (neg ? -box_size[ax] : box_size[ax]) - 2 * p[ax];
			// SystemVerilog division truncates toward zero.
			t = clamp_coord((num * (longint'(1) << FRAC_W)) / (2 * d[ax]));
			if (t > 0 && t < snap_thresh)
				t = 0;
			in_box = 1'b1;
			for (int i = 0; i < 3; i++) begin
				c[i] = p[i] + floor_frac(t * d[i] + (longint'(1) << (FRAC_W - 1)));
				if (i != ax && (2 * c[i] < -box_size[i] || 2 * c[i] > box_size[i]))
					in_box = 1'b0;
			end
			if (!in_box)
				continue;
			h = '0;
			h.hit_valid = 1'b1;
			h.distance = COORD_W'(t);
			h.hit_x = COORD_W'(clamp_coord(c[0]));
			h.hit_y = COORD_W'(clamp_coord(c[1]));
			h.hit_z = COORD_W'(clamp_coord(c[2]));
			h.face = FACE_W'(f);
			h.entering = neg ? (d[ax] > 0) : (d[ax] < 0);
			// Stable insert: equal distances keep face order.
			k = found.size();
			while (k > 0 && found[k-1].distance > h.distance)
				k--;
			found.insert(k, h);
		end
		if (found.size() == 0) begin
			h = '0;
			h.last = 1'b1;
			found.insert(0, h);
		end
		found[found.size()-1].last = 1'b1;
		foreach (found[j])
			pending_hits.insert(pending_hits.size(), found[j]);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_DAT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PRECISION)
			snap_thresh = value & ((longint'(1) << PREC_W) - 1);
		else
			box_size[idx] = value & ((longint'(1) << SIZE_W) - 1);
	endtask

	task automatic set_box(input longint sx, input longint sy, input longint sz,
			input longint prec);
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
		write_reg(CFG_PRECISION, prec);
	endtask

	// Valid stays high between back-to-back transactions; it drops only when idling.
	task automatic send_ray(input ray_in_t r);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		predict_hits(r);
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic ray_in_t make_ray(longint px, longint py, longint pz,
			longint dx, longint dy, longint dz);
		ray_in_t r;
		r.pos_x = COORD_W'(px); r.pos_y = COORD_W'(py); r.pos_z = COORD_W'(pz);
		r.dir_x = COORD_W'(dx); r.dir_y = COORD_W'(dy); r.dir_z = COORD_W'(dz);
		return r;
	endfunction

	// Value from a mix of small, near-box and full-range magnitudes.
	function automatic logic [31:0] rand_coord(input int scale);
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h0;
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(2 * scale)) - scale;
		endcase
	endfunction

	function automatic ray_in_t rand_ray(input int scale);
		ray_in_t r;
		r.pos_x = rand_coord(scale); r.pos_y = rand_coord(scale);
		r.pos_z = rand_coord(scale);
		r.dir_x = rand_coord(scale); r.dir_y = rand_coord(scale);
		r.dir_z = rand_coord(scale);
		return r;
	endfunction

	// Ray with origin within +-2^19 and direction within +-2^17 LSB of zero.
	function automatic ray_in_t aimed_ray();
		ray_in_t r;
		r.pos_x = $signed($urandom_range(1 << 20)) - (1 << 19);
		r.pos_y = $signed($urandom_range(1 << 20)) - (1 << 19);
		r.pos_z = $signed($urandom_range(1 << 20)) - (1 << 19);
		r.dir_x = $signed($urandom_range(1 << 18)) - (1 << 17);
		r.dir_y = $signed($urandom_range(1 << 18)) - (1 << 17);
		r.dir_z = $signed($urandom_range(1 << 18)) - (1 << 17);
		return r;
	endfunction

	task automatic test_reset_box();
		// Zero-size box straight after reset: only the origin plane can be hit.
		send_ray(make_ray(0, 0, -65536, 0, 0, 65536));
		send_ray(make_ray(65536, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_directed();
		set_box(4 << 16, 2 << 16, 6 << 16, 1);
		send_ray(make_ray(-10 << 16, 0, 0, 1 << 16, 0, 0));
		send_ray(make_ray(10 << 16, 0, 0, -(1 << 16), 0, 0));
		send_ray(make_ray(0, 0, 0, 0, 1 << 16, 0));
		send_ray(make_ray(0, 0, -20 << 16, 0, 0, 2 << 16));
		send_ray(make_ray(-10 << 16, -10 << 16, -10 << 16, 1 << 16, 1 << 16, 1 << 16));
		// Grazing an edge exactly on the bound.
		send_ray(make_ray(-10 << 16, 1 << 16, 0, 1 << 16, 0, 0));
		send_ray(make_ray(-10 << 16, 5 << 16, 0, 1 << 16, 0, 0));
		// Division overflow saturates the distance.
		send_ray(make_ray(32'h7fffffff, 0, 0, -1, 0, 0));
		send_ray(make_ray(32'h80000000, 0, 0, 1, 0, 0));
		send_ray(make_ray(32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000));
		send_ray(make_ray(32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff));
		drain();
		// Tiny positive distance snaps to zero under a large threshold.
		set_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff);
		send_ray(make_ray(32'h3fff0000, 0, 0, 32'h7fffffff, 0, 0));
		send_ray(make_ray(32'h3ffffff0, 5, -5, 32'h80000000, 32'h7fffffff, 1));
		send_ray(make_ray(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		drain();
		// Threshold zero disables snapping.
		set_box(2, 2, 2, 0);
		send_ray(make_ray(0, 0, 0, 32'h7fffffff, 0, 0));
		send_ray(make_ray(0, 0, 0, 1, 1, 1));
		drain();
	endtask

	task automatic test_random();
		int cfg_pick;
		for (int phase = 0; phase < 6; phase++) begin
			cfg_pick = $urandom_range(3);
			case (cfg_pick)
				0: set_box($urandom_range(1 << 22), $urandom_range(1 << 22),
					$urandom_range(1 << 22), $urandom_range(1 << 12));
				1: set_box(32'h7fffffff, $urandom, $urandom, $urandom);
				2: set_box(0, $urandom_range(1 << 21), 0, 1);
				default: set_box($urandom, $urandom, $urandom, 16'hffff);
			endcase
			calm = (phase == 3);
			for (int n = 0; n < 32; n++) begin
				if ($urandom_range(9) < 7)
					send_ray(aimed_ray());
				else
					send_ray(rand_ray(1 << ($urandom_range(30))));
			end
			drain();
		end
		calm = 1'b0;
	endtask

	// Receiver: random stalls, one long run with none.
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= calm || ($urandom_range(99) >= 37);
	end

	always @(posedge clk) begin
		hit_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_hits.size() == 0) begin
				$error("unexpected transaction %p", out_data);
				error_count++;
			end else begin
				want = pending_hits.pop_front();
				if (out_data.hit_valid !== want.hit_valid) begin
					$error("hit_valid exp %0d got %0d", want.hit_valid, out_data.hit_valid);
					error_count++;
				end
				if (out_data.distance !== want.distance) begin
					$error("distance exp %0d got %0d", want.distance, out_data.distance);
					error_count++;
				end
				if (out_data.hit_x !== want.hit_x) begin
					$error("hit_x exp %0d got %0d", want.hit_x, out_data.hit_x);
					error_count++;
				end
				if (out_data.hit_y !== want.hit_y) begin
					$error("hit_y exp %0d got %0d", want.hit_y, out_data.hit_y);
					error_count++;
				end
				if (out_data.hit_z !== want.hit_z) begin
					$error("hit_z exp %0d got %0d", want.hit_z, out_data.hit_z);
					error_count++;
				end
				if (out_data.face !== want.face) begin
					$error("face exp %0d got %0d", want.face, out_data.face);
					error_count++;
				end
				if (out_data.entering !== want.entering) begin
					$error("entering exp %0d got %0d", want.entering, out_data.entering);
					error_count++;
				end
				if (out_data.last !== want.last) begin
					$error("last exp %0d got %0d", want.last, out_data.last);
					error_count++;
				end
			end
		end
	end

	initial begin
		box_size[0] = 0; box_size[1] = 0; box_size[2] = 0;
		snap_thresh = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_box();
		test_directed();
		test_random();
		if (error_count == 0 && pending_hits.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
